>>> hw/rtl/smre_pkg.sv
// Shared types and constants for the serial mouse report engine.
// No dependencies; used by every module of the block.
`default_nettype none

package smre_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_MOTION = 2'd1,
    OP_BUTTON = 2'd2
  } op_e;

  // Host command bytes
  localparam logic [7:0] CMD_SELF_TEST = 8'h54;  // 'T'
  localparam logic [7:0] CMD_INCR_ON   = 8'h52;  // 'R'
  localparam logic [7:0] CMD_PROMPT    = 8'h50;  // 'P'

  // Button ids
  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_MIDDLE = 2'd1;
  localparam logic [1:0] BTN_RIGHT  = 2'd2;

  // Report header bits
  localparam logic [7:0] HDR_BASE   = 8'h80;
  localparam logic [7:0] HDR_DX_POS = 8'h10;
  localparam logic [7:0] HDR_DY_NEG = 8'h08;
  localparam logic [2:0] BIT_LEFT   = 3'h4;
  localparam logic [2:0] BIT_MIDDLE = 3'h2;
  localparam logic [2:0] BIT_RIGHT  = 3'h1;

  localparam logic [6:0] MAX_MOVE = 7'h7f;

  // Self-test reply bytes
  localparam logic [7:0] ST_BYTE0 = 8'h00;
  localparam logic [7:0] ST_BYTE1 = 8'h02;
  localparam logic [7:0] ST_BYTE2 = 8'h00;
  localparam logic [7:0] ST_BYTE3 = 8'h00;

  // One input request
  typedef struct packed {
    op_e                opcode;
    logic [7:0]         rx_byte;
    logic signed [15:0] move_dx;
    logic signed [15:0] move_dy;
    logic [1:0]         button_id;
    logic               pressed;
    logic               tx_room;
  } in_item_t;

  // One result byte
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } out_item_t;

  // Reply run queued between front and back
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic            four;  // four bytes, else three
  } job_t;

  // Head of the job queue as seen by the back end
  typedef struct packed {
    logic empty;
    job_t job;
  } head_t;

endpackage

`default_nettype wire

>>> hw/rtl/smre_front.sv
// Front end: takes requests, keeps mode and button state, builds reply runs.
// Depends on smre_pkg.
`default_nettype none

module smre_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_i,
  input  wire smre_pkg::in_item_t item_i,
  output logic                  job_valid_o,
  output smre_pkg::job_t        job_o
);

  logic [2:0] buttons_q, buttons_d;
  logic       incr_q, incr_d;
  logic [2:0] btn_mask;
  logic [2:0] hdr_buttons;
  logic [6:0] mag_x, mag_y;
  logic [7:0] rpt_hdr;

  // Saturated magnitude of a 16-bit two's complement value
  function automatic logic [6:0] sat_mag(input logic [15:0] v);
    logic [15:0] neg_v;
    neg_v = 16'd0 - v;
    if (v[15]) begin
      sat_mag = (v >= 16'hff81) ? neg_v[6:0] : smre_pkg::MAX_MOVE;
    end else begin
      sat_mag = (v > 16'h007f) ? smre_pkg::MAX_MOVE : v[6:0];
    end
  endfunction

  // Button bit selected by the request
  always_comb begin
    unique case (item_i.button_id)
      smre_pkg::BTN_LEFT:   btn_mask = smre_pkg::BIT_LEFT;
      smre_pkg::BTN_MIDDLE: btn_mask = smre_pkg::BIT_MIDDLE;
      smre_pkg::BTN_RIGHT:  btn_mask = smre_pkg::BIT_RIGHT;
      default:              btn_mask = 3'd0;
    endcase
  end

  // Motion report fields; a button event reports zero motion
  always_comb begin
    if (item_i.opcode == smre_pkg::OP_MOTION) begin
      mag_x   = sat_mag(item_i.move_dx);
      mag_y   = sat_mag(item_i.move_dy);
      rpt_hdr = smre_pkg::HDR_BASE | {5'd0, buttons_q}
              | (item_i.move_dx[15] ? 8'd0 : smre_pkg::HDR_DX_POS)
              | (item_i.move_dy[15] ? smre_pkg::HDR_DY_NEG : 8'd0);
    end else begin
      mag_x   = 7'd0;
      mag_y   = 7'd0;
      hdr_buttons = 3'd0;
      rpt_hdr = smre_pkg::HDR_BASE | {5'd0, buttons_d} | smre_pkg::HDR_DX_POS;
    end
    hdr_buttons = buttons_d;
  end

  // Decode request, update state, build reply
  always_comb begin
    buttons_d   = buttons_q;
    incr_d      = incr_q;
    job_valid_o = 1'b0;
    job_o.bytes = {rpt_hdr, 1'b0, mag_x, 1'b0, mag_y, 8'd0};
    job_o.four  = 1'b0;
    unique case (item_i.opcode)
      smre_pkg::OP_CMD: begin
        if (item_i.rx_byte == smre_pkg::CMD_SELF_TEST) begin
          job_valid_o = 1'b1;
          job_o.bytes = {smre_pkg::ST_BYTE0, smre_pkg::ST_BYTE1,
                         smre_pkg::ST_BYTE2, smre_pkg::ST_BYTE3};
          job_o.four  = 1'b1;
        end else if (item_i.rx_byte == smre_pkg::CMD_INCR_ON) begin
          incr_d = 1'b1;
        end else if (item_i.rx_byte == smre_pkg::CMD_PROMPT) begin
          incr_d      = 1'b0;
          job_valid_o = item_i.tx_room;
          job_o.bytes = {smre_pkg::HDR_BASE | {5'd0, hdr_buttons}, 8'd0, 8'd0, 8'd0};
        end
      end
      smre_pkg::OP_MOTION: begin
        job_valid_o = incr_q & item_i.tx_room;
      end
      smre_pkg::OP_BUTTON: begin
        buttons_d   = item_i.pressed ? (buttons_q | btn_mask) : (buttons_q & ~btn_mask);
        job_valid_o = incr_q & item_i.tx_room;
      end
      default: ;
    endcase
    if (!req_i) begin
      buttons_d   = buttons_q;
      incr_d      = incr_q;
      job_valid_o = 1'b0;
    end
  end

  // Mode and button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buttons_q <= 3'd0;
      incr_q    <= 1'b0;
    end else begin
      buttons_q <= buttons_d;
      incr_q    <= incr_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/smre_job_fifo.sv
// Small queue of reply runs between the front and back ends.
// Depends on smre_pkg.
`default_nettype none

module smre_job_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_i,
  input  wire smre_pkg::job_t wr_job_i,
  output logic                full_o,
  input  wire logic           rd_i,
  output smre_pkg::head_t     head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  smre_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o       = (cnt_q == FullCnt);
  assign head_o.empty = (cnt_q == '0);
  assign head_o.job   = mem_q[rd_ptr_q];
  assign do_wr        = wr_i & ~full_o;
  assign do_rd        = rd_i & ~head_o.empty;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/smre_back.sv
// Back end: walks the head reply run one byte per pop, flags the last byte.
// Depends on smre_pkg.
`default_nettype none

module smre_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire smre_pkg::head_t head_i,
  output logic                 rd_o,
  input  wire logic            pop,
  output logic                 empty,
  output smre_pkg::out_item_t  result_o
);

  logic [1:0] idx_q;
  logic       is_last;

  assign empty              = head_i.empty;
  assign is_last            = (idx_q == (head_i.job.four ? 2'd3 : 2'd2));
  assign result_o.tx_byte   = head_i.job.bytes[2'd3 - idx_q];
  assign result_o.last_byte = is_last;
  assign rd_o               = pop & ~head_i.empty & is_last;

  // Byte index within the run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (pop && !head_i.empty) begin
      idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/serial_mouse_report_engine_top.sv
// Serial mouse report engine, top level.
// Depends on smre_pkg, smre_front, smre_job_fifo, smre_back.
//
// Input channel (push/full): host command bytes, motion events and button
// events. A request is taken whenever full is low; the front end updates the
// mode and button state in that cycle and queues a reply run of 3 or 4 bytes,
// or nothing. While full is high every request waits, including one that
// replies nothing.
// Result channel (empty/pop): one byte per pop, the oldest byte shown
// while empty is low, last_byte marking the end of each run.
// A reply run is registered in the job queue and shows its first byte once
// the runs ahead of it are out. The output port gives one result byte per
// cycle while pop is high and empty is low, and it is what limits the rate.
// Up to FifoDepth replies are held while the receiver stalls; full rises when
// they are all occupied, and requests then wait.
// Reset clears the button bits, turns incremental mode off and empties the
// queue; full is then low, so requests are taken as soon as reset is released.
`default_nettype none

module serial_mouse_report_engine_top #(
  parameter int unsigned FifoDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire smre_pkg::in_item_t  item_i,
  output logic                     empty,
  input  wire logic                pop,
  output smre_pkg::out_item_t      result_o
);

  logic            req;
  logic            job_valid;
  smre_pkg::job_t  job;
  smre_pkg::head_t head;
  logic            rd;

  assign req = push & ~full;

  smre_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .item_i      (item_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  smre_job_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (job_valid),
    .wr_job_i (job),
    .full_o   (full),
    .rd_i     (rd),
    .head_o   (head)
  );

  smre_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .rd_o     (rd),
    .pop      (pop),
    .empty    (empty),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_serial_mouse_report_engine_top.sv
// Testbench for serial_mouse_report_engine_top: directed and random requests
// with random stalls on both sides, every reply byte checked against a predictor.
// Depends on smre_pkg and the RTL of the block.
`default_nettype none

module tb_serial_mouse_report_engine_top;
  import smre_pkg::*;

  // Codes outside the legal range, sent on purpose
  localparam op_e        OP_ILLEGAL = op_e'(2'd3);
  localparam logic [1:0] BTN_NONE   = 2'd3;
  localparam int         MAX_WAIT   = 11;
  localparam int         RAND_REQS  = 400;

  typedef struct {
    in_item_t req;
    bit       drain;  // hold off until every pending reply byte is out
    bit       burst;  // no idling on either side around this request
  } req_slot_t;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push   = 1'b0;
  logic      pop    = 1'b0;
  in_item_t  item   = '0;
  logic      full;
  logic      empty;
  out_item_t result_o;

  req_slot_t req_q[$];
  out_item_t reply_q[$];

  // Predictor state
  logic [2:0] btn_state = '0;
  bit         incr_on   = 1'b0;

  bit        req_taken = 1'b0;
  bit        res_taken = 1'b0;
  bit        cur_burst = 1'b0;
  int        send_wait = 0;
  int        pop_wait  = 0;
  int        errors    = 0;
  int        bytes_out = 0;
  logic      push_next;
  req_slot_t slot;
  out_item_t want;

  serial_mouse_report_engine_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always #4 clk_i = ~clk_i;

  // Magnitude of a motion value, saturated to the report range
  function automatic logic [7:0] clip_mag(logic signed [15:0] v);
    int m;
    m = v;
    if (m < 0) m = -m;
    return (m > MAX_MOVE) ? {1'b0, MAX_MOVE} : 8'(m);
  endfunction

  // Three-byte report, sent only in incremental mode with room
  function automatic void motion_report(logic signed [15:0] dx, logic signed [15:0] dy,
                                        logic room);
    logic [7:0] hdr;
    hdr = HDR_BASE | {5'b0, btn_state};
    if (!dx[15]) hdr |= HDR_DX_POS;
    if (dy[15]) hdr |= HDR_DY_NEG;
    if (!incr_on || !room) return;
    reply_q.push_back(out_item_t'{tx_byte: hdr, last_byte: 1'b0});
    reply_q.push_back(out_item_t'{tx_byte: clip_mag(dx), last_byte: 1'b0});
    reply_q.push_back(out_item_t'{tx_byte: clip_mag(dy), last_byte: 1'b1});
  endfunction

  // Update mode and buttons for one request, queue the bytes it replies
  function automatic void predict_reply(in_item_t r);
    logic [2:0] sel;
    case (r.opcode)
      OP_CMD: begin
        if (r.rx_byte == CMD_SELF_TEST) begin
          reply_q.push_back(out_item_t'{tx_byte: ST_BYTE0, last_byte: 1'b0});
          reply_q.push_back(out_item_t'{tx_byte: ST_BYTE1, last_byte: 1'b0});
          reply_q.push_back(out_item_t'{tx_byte: ST_BYTE2, last_byte: 1'b0});
          reply_q.push_back(out_item_t'{tx_byte: ST_BYTE3, last_byte: 1'b1});
        end else if (r.rx_byte == CMD_INCR_ON) begin
          incr_on = 1'b1;
        end else if (r.rx_byte == CMD_PROMPT) begin
          incr_on = 1'b0;
          if (r.tx_room) begin
            reply_q.push_back(out_item_t'{tx_byte: HDR_BASE | {5'b0, btn_state},
                                          last_byte: 1'b0});
            reply_q.push_back(out_item_t'{tx_byte: 8'h00, last_byte: 1'b0});
            reply_q.push_back(out_item_t'{tx_byte: 8'h00, last_byte: 1'b1});
          end
        end
      end
      OP_MOTION: motion_report(r.move_dx, r.move_dy, r.tx_room);
      OP_BUTTON: begin
        case (r.button_id)
          BTN_LEFT:   sel = BIT_LEFT;
          BTN_MIDDLE: sel = BIT_MIDDLE;
          BTN_RIGHT:  sel = BIT_RIGHT;
          default:    sel = 3'b000;
        endcase
        if (r.pressed) btn_state |= sel;
        else btn_state &= ~sel;
        motion_report(16'sd0, 16'sd0, r.tx_room);
      end
      default: ;
    endcase
  endfunction

  function automatic void log_mismatch(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Request with random bits in every field, opcode to be set by the caller
  function automatic in_item_t noise_req();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t make_req(op_e op, logic [7:0] rx, int dx, int dy,
                                        logic [1:0] id, bit prs, bit room);
    in_item_t r;
    r           = noise_req();
    r.opcode    = op;
    r.rx_byte   = rx;
    r.move_dx   = 16'(dx);
    r.move_dy   = 16'(dy);
    r.button_id = id;
    r.pressed   = prs;
    r.tx_room   = room;
    return r;
  endfunction

  function automatic void queue_req(in_item_t r, bit drain, bit burst);
    req_slot_t s;
    s.req   = r;
    s.drain = drain;
    s.burst = burst;
    req_q.push_back(s);
  endfunction

  // Sender: present requests from the queue with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      push_next = push;
      if (push && req_taken) begin
        push_next = 1'b0;
        send_wait = cur_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!push_next) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (req_q.size() != 0 && !(req_q[0].drain && reply_q.size() != 0)) begin
          slot      = req_q.pop_front();
          item      <= slot.req;
          cur_burst = slot.burst;
          push_next = 1'b1;
        end
      end
      push <= push_next;
    end
  end

  // Receiver: random stall before each reply byte
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pop && res_taken) pop_wait = cur_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (pop_wait != 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Monitor: check reply bytes, predict on every accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      req_taken <= push && !full;
      res_taken <= pop && !empty;
      if (pop && !empty) begin
        if (reply_q.size() == 0) begin
          log_mismatch($sformatf("byte %0d: unexpected tx_byte %02h last_byte %0b",
                                 bytes_out, result_o.tx_byte, result_o.last_byte));
        end else begin
          want = reply_q.pop_front();
          if (result_o.tx_byte !== want.tx_byte || result_o.last_byte !== want.last_byte)
            log_mismatch($sformatf("byte %0d: tx_byte exp %02h got %02h, last_byte exp %0b got %0b",
                                   bytes_out, want.tx_byte, result_o.tx_byte,
                                   want.last_byte, result_o.last_byte));
        end
        bytes_out++;
      end
      if (push && !full) predict_reply(item);
    end
  end

  // Stimulus and end of run
  initial begin
    in_item_t r;
    int       pick;
    int       counted;
    bit       useful;
    int       corner_vals[8] = '{-32768, 32767, -128, 127, 128, -127, 0, -1};

    // Directed: mode off, self-test, prompt, saturation corners, buttons, odd codes
    queue_req(make_req(OP_MOTION, 8'h00, 5, 5, BTN_LEFT, 0, 1), 0, 0);
    queue_req(make_req(OP_BUTTON, 8'h00, 0, 0, BTN_LEFT, 1, 1), 0, 0);
    queue_req(make_req(OP_CMD, CMD_SELF_TEST, 0, 0, BTN_LEFT, 0, 0), 0, 0);
    queue_req(make_req(OP_CMD, CMD_PROMPT, 0, 0, BTN_LEFT, 0, 1), 0, 0);
    queue_req(make_req(OP_CMD, CMD_PROMPT, 0, 0, BTN_LEFT, 0, 0), 0, 0);
    queue_req(make_req(OP_CMD, CMD_INCR_ON, 0, 0, BTN_LEFT, 0, 1), 0, 0);
    queue_req(make_req(OP_MOTION, 8'h00, 0, 0, BTN_LEFT, 0, 1), 0, 0);
    queue_req(make_req(OP_MOTION, 8'hff, 32767, -32768, BTN_NONE, 1, 1), 0, 1);
    queue_req(make_req(OP_MOTION, 8'hff, -32768, 32767, BTN_NONE, 1, 1), 0, 1);
    queue_req(make_req(OP_MOTION, 8'h00, -1, 1, BTN_LEFT, 0, 1), 0, 0);
    queue_req(make_req(OP_MOTION, 8'h00, 127, -127, BTN_LEFT, 0, 1), 0, 0);
    queue_req(make_req(OP_MOTION, 8'h00, 128, -128, BTN_LEFT, 0, 1), 0, 0);
    queue_req(make_req(OP_MOTION, 8'h00, 5, 5, BTN_LEFT, 0, 0), 0, 0);
    queue_req(make_req(OP_BUTTON, 8'h00, 0, 0, BTN_MIDDLE, 1, 1), 0, 0);
    queue_req(make_req(OP_BUTTON, 8'h00, 0, 0, BTN_RIGHT, 1, 1), 0, 0);
    queue_req(make_req(OP_BUTTON, 8'h00, 0, 0, BTN_NONE, 1, 1), 0, 0);
    queue_req(make_req(OP_BUTTON, 8'h00, 0, 0, BTN_LEFT, 0, 1), 0, 0);
    queue_req(make_req(OP_CMD, 8'hff, 0, 0, BTN_LEFT, 0, 1), 1, 0);
    queue_req(make_req(OP_ILLEGAL, 8'hff, -1, -1, BTN_NONE, 1, 1), 0, 0);
    queue_req(make_req(OP_CMD, 8'h00, 0, 0, BTN_LEFT, 0, 1), 0, 0);
    queue_req(make_req(OP_BUTTON, 8'h00, 0, 0, BTN_MIDDLE, 0, 0), 0, 0);
    queue_req(make_req(OP_CMD, CMD_PROMPT, 0, 0, BTN_LEFT, 0, 1), 0, 0);
    queue_req(make_req(OP_MOTION, 8'h00, 10, 10, BTN_LEFT, 0, 1), 0, 0);
    queue_req(make_req(OP_CMD, CMD_INCR_ON, 0, 0, BTN_LEFT, 0, 1), 0, 0);
    queue_req(make_req(OP_CMD, CMD_SELF_TEST, 0, 0, BTN_LEFT, 0, 1), 0, 0);

    // Random: mostly motion and buttons in incremental mode, some commands and noise
    counted = 0;
    while (counted < RAND_REQS) begin
      r         = noise_req();
      useful    = 1'b1;
      r.tx_room = ($urandom_range(0, 9) != 0);
      pick      = $urandom_range(0, 99);
      if (pick < 7) begin
        r.opcode  = OP_CMD;
        r.rx_byte = CMD_INCR_ON;
      end else if (pick < 11) begin
        r.opcode  = OP_CMD;
        r.rx_byte = CMD_PROMPT;
      end else if (pick < 16) begin
        r.opcode  = OP_CMD;
        r.rx_byte = CMD_SELF_TEST;
      end else if (pick < 19) begin
        r.opcode = OP_CMD;
        useful   = (r.rx_byte == CMD_SELF_TEST || r.rx_byte == CMD_INCR_ON ||
                    r.rx_byte == CMD_PROMPT);
      end else if (pick < 21) begin
        r.opcode = OP_ILLEGAL;
        useful   = 1'b0;
      end else if (pick < 62) begin
        r.opcode = OP_MOTION;
        case ($urandom_range(0, 3))
          0: begin
            r.move_dx = 16'($signed($urandom_range(0, 16)) - 8);
            r.move_dy = 16'($signed($urandom_range(0, 16)) - 8);
          end
          1: begin
            r.move_dx = 16'($signed($urandom_range(0, 280)) - 140);
            r.move_dy = 16'($signed($urandom_range(0, 280)) - 140);
          end
          2: ;  // keep full-range noise
          default: begin
            r.move_dx = 16'(corner_vals[$urandom_range(0, 7)]);
            r.move_dy = 16'(corner_vals[$urandom_range(0, 7)]);
          end
        endcase
      end else begin
        r.opcode = OP_BUTTON;
      end
      queue_req(r, (counted % 97) == 50, (counted % 150) >= 120);
      if (useful) counted++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all requests taken, all reply bytes out, then a short tail.
    // Sampled at the rising edge, where push and the request queue are settled.
    while (req_q.size() != 0 || push) @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (16) @(negedge clk_i);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
